// ===== hw/rtl/satc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package satc_pkg;

	localparam int ADDR_W     = 32;
	localparam int WAY_W      = 2;
	localparam int OUT_CNT_W  = 32;
	localparam int NUM_CNT    = 6;

	localparam int WL_W       = 2;
	localparam int OFS_W      = 5;
	localparam int IB_W       = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 3'd4;

	// reset values of the ways, offset and index configuration registers
	localparam logic [WL_W-1:0]  RST_WAYS_LOG2   = 2'd0;
	localparam logic [OFS_W-1:0] RST_OFFSET_BITS = 5'd4;
	localparam logic [IB_W-1:0]  RST_INDEX_BITS  = 4'd6;

	// statistics counter slots
	localparam int CNT_RD_HIT  = 0;
	localparam int CNT_WR_HIT  = 1;
	localparam int CNT_RD_MISS = 2;
	localparam int CNT_WR_MISS = 3;
	localparam int CNT_WB      = 4;
	localparam int CNT_MEM_WR  = 5;

	typedef struct packed {
		logic clear;
		logic accept;
		logic lookup;
		logic load_out;
		logic load_hold;
		logic hold_to_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

	typedef struct packed {
		logic                                hit;
		logic [WAY_W-1:0]                    way;
		logic                                writeback;
		logic                                memory_write;
		logic [NUM_CNT-1:0][OUT_CNT_W-1:0]   cnt;
	} res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/satc_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface satc_req_if;
	import satc_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] address;
	modport source (output valid, output req_type, output address, input ready);
	modport sink (input valid, input req_type, input address, output ready);
endinterface

interface satc_res_if;
	import satc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [WAY_W-1:0]     way;
	logic                 writeback;
	logic                 memory_write;
	logic [OUT_CNT_W-1:0] read_hit_count;
	logic [OUT_CNT_W-1:0] write_hit_count;
	logic [OUT_CNT_W-1:0] read_miss_count;
	logic [OUT_CNT_W-1:0] write_miss_count;
	logic [OUT_CNT_W-1:0] writeback_count;
	logic [OUT_CNT_W-1:0] memory_write_count;
	modport source (output valid, output hit, output way, output writeback,
		output memory_write, output read_hit_count, output write_hit_count,
		output read_miss_count, output write_miss_count, output writeback_count,
		output memory_write_count, input ready);
	modport sink (input valid, input hit, input way, input writeback,
		input memory_write, input read_hit_count, input write_hit_count,
		input read_miss_count, input write_miss_count, input writeback_count,
		input memory_write_count, output ready);
endinterface

interface satc_cfg_if;
	import satc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/satc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module satc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/satc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module satc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  satc_pkg::sts_t sts,
	output satc_pkg::cmd_t cmd
);
	import satc_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_LOOKUP = 4'b0100,
		ST_STALL  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.load_hold = 1'b1;
					state_d       = ST_STALL;
				end
			end
			ST_STALL: begin
				if (out_free) begin
					cmd.hold_to_out = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out || cmd.hold_to_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/satc_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module satc_dpath #(
	parameter int MAX_INDEX_BITS = 10,
	parameter int MAX_WAYS       = 4,
	parameter int ADDRESS_BITS   = 32,
	parameter int COUNT_BITS     = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  satc_pkg::cmd_t                  cmd,
	output satc_pkg::sts_t                  sts,
	input  logic                            cfg_we,
	input  logic [satc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [satc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            req_type,
	input  logic [satc_pkg::ADDR_W-1:0]     address,
	output satc_pkg::res_t                  res
);
	import satc_pkg::*;

	localparam int NUM_SETS = 1 << MAX_INDEX_BITS;
	localparam int EFF_AW   = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam int ROW_W    = 2 * MAX_WAYS + WAY_W;
	localparam int PTR_LSB  = 2 * MAX_WAYS;

	// configuration
	logic [WL_W-1:0]  ways_log2_q;
	logic [OFS_W-1:0] offset_bits_q;
	logic [IB_W-1:0]  index_bits_q;
	logic             write_back_q;
	logic             write_allocate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_log2_q      <= RST_WAYS_LOG2;
			offset_bits_q    <= RST_OFFSET_BITS;
			index_bits_q     <= RST_INDEX_BITS;
			write_back_q     <= 1'b1;
			write_allocate_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WAYS_LOG2:      ways_log2_q      <= cfg_data[WL_W-1:0];
				CFG_OFFSET_BITS:    offset_bits_q    <= cfg_data[OFS_W-1:0];
				CFG_INDEX_BITS:     index_bits_q     <= cfg_data[IB_W-1:0];
				CFG_WRITE_BACK:     write_back_q     <= cfg_data[0];
				CFG_WRITE_ALLOCATE: write_allocate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// address split
	logic [IB_W-1:0]           ib_eff;
	logic [2:0]                nways;
	logic [ADDR_W-1:0]         addr_m;
	logic [ADDR_W-1:0]         shifted;
	logic [MAX_INDEX_BITS-1:0] set_c;
	logic [EFF_AW-1:0]         tag_c;

	always_comb begin
		ib_eff = (index_bits_q > IB_W'(MAX_INDEX_BITS)) ? IB_W'(MAX_INDEX_BITS) : index_bits_q;
		if (ways_log2_q == 2'd3) begin
			nways = 3'd4;
		end else begin
			nways = 3'd1 << ways_log2_q;
		end
		if (nways > 3'(MAX_WAYS)) begin
			nways = 3'(MAX_WAYS);
		end
		addr_m  = ADDR_W'(address[EFF_AW-1:0]);
		shifted = addr_m >> offset_bits_q;
		set_c   = shifted[MAX_INDEX_BITS-1:0] & ~({MAX_INDEX_BITS{1'b1}} << ib_eff);
		tag_c   = EFF_AW'(shifted >> ib_eff);
	end

	logic [MAX_INDEX_BITS-1:0] set_s1;
	logic [EFF_AW-1:0]         tag_s1;
	logic                      wr_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_s1 <= set_c;
			tag_s1 <= tag_c;
			wr_s1  <= req_type;
		end
	end

	// clearing pass over the status rows
	logic [MAX_INDEX_BITS-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_addr_q == {MAX_INDEX_BITS{1'b1}});

	// status row: valid/dirty pair per way, then the FIFO pointer
	logic [ROW_W-1:0]  row_rd;
	logic [ROW_W-1:0]  row_wr;
	logic [EFF_AW-1:0] tag_rd [MAX_WAYS];
	logic              fill;
	logic [WAY_W-1:0]  victim;

	satc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_status_ram (
		.clk   (clk),
		.we    (cmd.clear || cmd.lookup),
		.waddr (cmd.clear ? clr_addr_q : set_s1),
		.wdata (cmd.clear ? {ROW_W{1'b0}} : row_wr),
		.raddr (set_c),
		.rdata (row_rd)
	);

	for (genvar w = 0; w < MAX_WAYS; w++) begin : g_tag
		satc_ram #(
			.WIDTH (EFF_AW),
			.DEPTH (NUM_SETS)
		) u_tag_ram (
			.clk   (clk),
			.we    (cmd.lookup && fill && (victim == WAY_W'(w))),
			.waddr (set_s1),
			.wdata (tag_s1),
			.raddr (set_c),
			.rdata (tag_rd[w])
		);
	end

	// lookup and update
	logic                  hit;
	logic [WAY_W-1:0]      hit_way;
	logic [WAY_W-1:0]      ptr;
	logic [2:0]            victim_inc;
	logic                  wb_out;
	logic                  mw_out;
	logic [WAY_W-1:0]      way_out;
	logic [NUM_CNT-1:0]    bump;
	logic [COUNT_BITS-1:0] cnt_q  [NUM_CNT];
	logic [COUNT_BITS-1:0] cnt_nx [NUM_CNT];
	res_t                  res_c;
	res_t                  hold_q;
	res_t                  res_q;

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (!hit && (3'(w) < nways) && row_rd[2*w] && (tag_rd[w] == tag_s1)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end

		ptr        = row_rd[PTR_LSB +: WAY_W];
		victim     = ({1'b0, ptr} >= nways) ? '0 : ptr;
		victim_inc = {1'b0, victim} + 3'd1;
		fill       = !hit && (!wr_s1 || write_allocate_q);

		wb_out = 1'b0;
		row_wr = row_rd;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (fill && (victim == WAY_W'(w))) begin
				wb_out       = row_rd[2*w] && row_rd[2*w+1];
				row_wr[2*w]   = 1'b1;
				row_wr[2*w+1] = wr_s1 && write_back_q;
			end
			if (hit && (hit_way == WAY_W'(w)) && wr_s1 && write_back_q) begin
				row_wr[2*w+1] = 1'b1;
			end
		end
		if (fill) begin
			row_wr[PTR_LSB +: WAY_W] = (victim_inc >= nways) ? '0 : victim_inc[WAY_W-1:0];
		end

		if (hit) begin
			mw_out = wr_s1 && !write_back_q;
		end else begin
			mw_out = wr_s1 && (!write_back_q || !write_allocate_q);
		end

		if (hit) begin
			way_out = hit_way;
		end else if (fill) begin
			way_out = victim;
		end else begin
			way_out = '0;
		end

		bump              = '0;
		bump[CNT_RD_HIT]  = hit && !wr_s1;
		bump[CNT_WR_HIT]  = hit && wr_s1;
		bump[CNT_RD_MISS] = !hit && !wr_s1;
		bump[CNT_WR_MISS] = !hit && wr_s1;
		bump[CNT_WB]      = wb_out;
		bump[CNT_MEM_WR]  = mw_out;

		res_c.hit          = hit;
		res_c.way          = way_out;
		res_c.writeback    = wb_out;
		res_c.memory_write = mw_out;
		for (int i = 0; i < NUM_CNT; i++) begin
			// saturate at all ones
			if (bump[i] && (cnt_q[i] != {COUNT_BITS{1'b1}})) begin
				cnt_nx[i] = cnt_q[i] + 1'b1;
			end else begin
				cnt_nx[i] = cnt_q[i];
			end
			res_c.cnt[i] = OUT_CNT_W'(cnt_nx[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.lookup) begin
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= cnt_nx[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hold) begin
			hold_q <= res_c;
		end
		if (cmd.load_out) begin
			res_q <= res_c;
		end else if (cmd.hold_to_out) begin
			res_q <= hold_q;
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ===== hw/rtl/set_assoc_cache_tag_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The result is loaded into the output register from the lookup state after the accept, or via the
// hold register and the stall state while the output is still full. A new item is taken only back
// in idle, after the read-modify-write of the set's status and tag memories (read on accept, compare
// and write back in the next cycle), even while the previous result still waits in the output
// register. Reset: asynchronous; config to defaults, counters clear; a pass over all 2**MAX_INDEX_BITS
// status rows (1024 by default) zeroes valid, dirty and FIFO state, taking config writes but no item.
module set_assoc_cache_tag_controller #(
	parameter int MAX_INDEX_BITS = 10,
	parameter int MAX_WAYS       = 4,
	parameter int ADDRESS_BITS   = 32,
	parameter int COUNT_BITS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	satc_req_if.sink    req,
	satc_res_if.source  res,
	satc_cfg_if.sink    cfg
);
	import satc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res_pl;

	assign cfg.ready = 1'b1;

	satc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	satc_dpath #(
		.MAX_INDEX_BITS (MAX_INDEX_BITS),
		.MAX_WAYS       (MAX_WAYS),
		.ADDRESS_BITS   (ADDRESS_BITS),
		.COUNT_BITS     (COUNT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.req_type  (req.req_type),
		.address   (req.address),
		.res       (res_pl)
	);

	assign res.hit                = res_pl.hit;
	assign res.way                = res_pl.way;
	assign res.writeback          = res_pl.writeback;
	assign res.memory_write       = res_pl.memory_write;
	assign res.read_hit_count     = res_pl.cnt[CNT_RD_HIT];
	assign res.write_hit_count    = res_pl.cnt[CNT_WR_HIT];
	assign res.read_miss_count    = res_pl.cnt[CNT_RD_MISS];
	assign res.write_miss_count   = res_pl.cnt[CNT_WR_MISS];
	assign res.writeback_count    = res_pl.cnt[CNT_WB];
	assign res.memory_write_count = res_pl.cnt[CNT_MEM_WR];
endmodule
`default_nettype wire
